/* rtl/tes_pkg.sv */
// Package with item types and encoding codes for the text encoding sniffer.
package tes_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [2:0] encoding_code;
    logic       bom_used;
    logic [2:0] bom_bytes;
    logic       detect_ok;
  } out_item_t;

  // Encoding codes reported in encoding_code.
  localparam logic [2:0] ENC_DEFAULT = 3'd0;
  localparam logic [2:0] ENC_UTF8    = 3'd1;
  localparam logic [2:0] ENC_UTF16BE = 3'd2;
  localparam logic [2:0] ENC_UTF16LE = 3'd3;
  localparam logic [2:0] ENC_UTF32BE = 3'd4;
  localparam logic [2:0] ENC_UTF32LE = 3'd5;

  // Byte order mark lengths.
  localparam logic [2:0] BOM_LEN_NONE = 3'd0;
  localparam logic [2:0] BOM_LEN_16   = 3'd2;
  localparam logic [2:0] BOM_LEN_8    = 3'd3;
  localparam logic [2:0] BOM_LEN_32   = 3'd4;

  // UTF-8 heuristic verdicts.
  localparam logic [1:0] U8_UNDECIDED = 2'd0;
  localparam logic [1:0] U8_YES       = 2'd1;
  localparam logic [1:0] U8_NO        = 2'd2;

  // Largest Unicode scalar value.
  localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;

endpackage

/* rtl/tes_scan.sv */
// Per-buffer scan state and verdict logic of the text encoding sniffer.
module tes_scan #(
  parameter int MIN_WIDE_WORDS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  tes_pkg::in_item_t  item,
  output tes_pkg::out_item_t verdict
);

  localparam logic [2:0] MinWords = 3'(MIN_WIDE_WORDS);

  logic [31:0] head_bytes, head_bytes_next;
  logic [2:0]  byte_count, byte_count_next;
  logic [1:0]  lane_phase, lane_phase_next;
  logic [23:0] word_hold, word_hold_next;
  logic [1:0]  u8_verdict, u8_verdict_next;
  logic [2:0]  u8_tails, u8_tails_next;
  logic [2:0]  be16_flags, be16_flags_next;
  logic [2:0]  le16_flags, le16_flags_next;
  logic [1:0]  wide_fail, wide_fail_next;
  logic [2:0]  word_count, word_count_next;

  logic [7:0]  b;
  logic [31:0] be_word, le_word;
  logic        wide_ok;
  logic [7:0]  h0, h1, h2, h3;

  // Flags: bit 0 saw a valid unit with a zero high byte, bit 1 open high
  // surrogate, bit 2 failed.
  function automatic logic [2:0] pair_update(input logic [2:0] f,
                                             input logic [7:0] hi,
                                             input logic [7:0] lo);
    logic [2:0] r;
    r = f;
    if (!f[2]) begin
      if (hi == 8'h00) begin
        if (lo == 8'h00) r[2] = 1'b1;
        else r[0] = 1'b1;
      end else if (hi >= 8'hD8 && hi <= 8'hDB) begin
        if (f[1]) r[2] = 1'b1;
        else r[1] = 1'b1;
      end else if (hi >= 8'hDC && hi <= 8'hDF) begin
        if (!f[1]) r[2] = 1'b1;
        else r[1] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic word_bad(input logic [31:0] w);
    return (w == 32'h0) || (w > tes_pkg::MAX_CODE_POINT);
  endfunction

  assign b       = item.data_byte;
  assign be_word = {word_hold, b};
  assign le_word = {b, word_hold[7:0], word_hold[15:8], word_hold[23:16]};

  // State after this item's byte.
  always_comb begin
    head_bytes_next = head_bytes;
    byte_count_next = byte_count;
    lane_phase_next = lane_phase;
    word_hold_next  = word_hold;
    u8_verdict_next = u8_verdict;
    u8_tails_next   = u8_tails;
    be16_flags_next = be16_flags;
    le16_flags_next = le16_flags;
    wide_fail_next  = wide_fail;
    word_count_next = word_count;
    if (item.byte_present) begin
      if (byte_count < 3'd4) begin
        head_bytes_next[{byte_count[1:0], 3'b000} +: 8] = b;
      end
      if (byte_count != 3'd7) byte_count_next = byte_count + 3'd1;

      if (u8_verdict == tes_pkg::U8_UNDECIDED) begin
        if (u8_tails != 3'd0) begin
          if (b[7:6] == 2'b10) begin
            u8_tails_next = u8_tails - 3'd1;
            if (u8_tails == 3'd1) u8_verdict_next = tes_pkg::U8_YES;
          end else begin
            u8_verdict_next = tes_pkg::U8_NO;
          end
        end else if (b[7]) begin
          if (b <= 8'hDF) u8_tails_next = 3'd1;
          else if (b <= 8'hEF) u8_tails_next = 3'd2;
          else if (b <= 8'hF4) u8_tails_next = 3'd3;
          else if (b <= 8'hFB) u8_tails_next = 3'd4;
          else u8_verdict_next = tes_pkg::U8_NO;
        end
      end

      if (lane_phase[0]) begin
        be16_flags_next = pair_update(be16_flags, word_hold[7:0], b);
        le16_flags_next = pair_update(le16_flags, b, word_hold[7:0]);
      end

      if (lane_phase == 2'd3) begin
        if (word_bad(be_word)) wide_fail_next[0] = 1'b1;
        if (word_bad(le_word)) wide_fail_next[1] = 1'b1;
        if (word_count != 3'd7) word_count_next = word_count + 3'd1;
      end

      word_hold_next  = {word_hold[15:0], b};
      lane_phase_next = lane_phase + 2'd1;
    end
  end

  assign h0      = head_bytes_next[7:0];
  assign h1      = head_bytes_next[15:8];
  assign h2      = head_bytes_next[23:16];
  assign h3      = head_bytes_next[31:24];
  assign wide_ok = word_count_next >= MinWords;

  // Verdict for the buffer as it stands after this item.
  always_comb begin
    verdict = '0;
    if (byte_count_next != 3'd0) begin
      verdict.detect_ok = 1'b1;
      if (byte_count_next >= 3'd4) begin
        verdict.bom_used = 1'b1;
        if (h0 == 8'hEF && h1 == 8'hBB && h2 == 8'hBF) begin
          verdict.encoding_code = tes_pkg::ENC_UTF8;
          verdict.bom_bytes     = tes_pkg::BOM_LEN_8;
        end else if (h0 == 8'h00 && h1 == 8'h00 && h2 == 8'hFE && h3 == 8'hFF) begin
          verdict.encoding_code = tes_pkg::ENC_UTF32BE;
          verdict.bom_bytes     = tes_pkg::BOM_LEN_32;
        end else if (h0 == 8'hFF && h1 == 8'hFE && h2 == 8'h00 && h3 == 8'h00) begin
          verdict.encoding_code = tes_pkg::ENC_UTF32LE;
          verdict.bom_bytes     = tes_pkg::BOM_LEN_32;
        end else if (h0 == 8'hFE && h1 == 8'hFF) begin
          verdict.encoding_code = tes_pkg::ENC_UTF16BE;
          verdict.bom_bytes     = tes_pkg::BOM_LEN_16;
        end else if (h0 == 8'hFF && h1 == 8'hFE) begin
          verdict.encoding_code = tes_pkg::ENC_UTF16LE;
          verdict.bom_bytes     = tes_pkg::BOM_LEN_16;
        end else begin
          verdict.bom_used = 1'b0;
        end
      end
      if (!verdict.bom_used) begin
        verdict.bom_bytes = tes_pkg::BOM_LEN_NONE;
        if (u8_verdict_next == tes_pkg::U8_YES) begin
          verdict.encoding_code = tes_pkg::ENC_UTF8;
        end else if (be16_flags_next[2] == 1'b0 && be16_flags_next[0]) begin
          verdict.encoding_code = tes_pkg::ENC_UTF16BE;
        end else if (le16_flags_next[2] == 1'b0 && le16_flags_next[0]) begin
          verdict.encoding_code = tes_pkg::ENC_UTF16LE;
        end else if (wide_ok && !wide_fail_next[0]) begin
          verdict.encoding_code = tes_pkg::ENC_UTF32BE;
        end else if (wide_ok && !wide_fail_next[1]) begin
          verdict.encoding_code = tes_pkg::ENC_UTF32LE;
        end else begin
          verdict.encoding_code = tes_pkg::ENC_DEFAULT;
        end
      end
    end
  end

  // A verdict closes the buffer and returns the scan state to its start.
  always_ff @(posedge clk) begin
    if (rst || (take && item.end_of_buffer)) begin
      head_bytes <= '0;
      byte_count <= '0;
      lane_phase <= '0;
      word_hold  <= '0;
      u8_verdict <= tes_pkg::U8_UNDECIDED;
      u8_tails   <= '0;
      be16_flags <= '0;
      le16_flags <= '0;
      wide_fail  <= '0;
      word_count <= '0;
    end else if (take) begin
      head_bytes <= head_bytes_next;
      byte_count <= byte_count_next;
      lane_phase <= lane_phase_next;
      word_hold  <= word_hold_next;
      u8_verdict <= u8_verdict_next;
      u8_tails   <= u8_tails_next;
      be16_flags <= be16_flags_next;
      le16_flags <= le16_flags_next;
      wide_fail  <= wide_fail_next;
      word_count <= word_count_next;
    end
  end

endmodule

/* rtl/text_encoding_sniffer_unit.sv */
// Top level of the text encoding sniffer: handshakes, input and result registers.
//
// The sniffer takes a text buffer one byte per item and, on the item that
// carries end_of_buffer, returns one verdict: the likely Unicode encoding,
// whether a byte order mark opened the buffer and how long it was, and
// detect_ok, which is low only for an empty buffer. An item with
// byte_present low carries no byte; with end_of_buffer high it still closes
// the buffer. The block takes one item in every cycle while in_stall is low.
// Each accepted item is held in the input register, then the scan logic
// updates its flag registers and, for the last item of a buffer, loads the
// verdict into the result register, which raises out_valid. Items that
// carry no end mark keep flowing while a verdict waits on out_stall; only
// a second end item waits behind it, and the input then raises in_stall.
// After a verdict the scan state is cleared at once, so the next buffer
// may start in the following cycle. MIN_WIDE_WORDS (1 to 7) sets how many
// complete 32-bit words the UTF-32 checks need.
module text_encoding_sniffer_unit #(
  parameter int MIN_WIDE_WORDS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tes_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tes_pkg::out_item_t out_item
);

  logic               in_q_valid;
  tes_pkg::in_item_t  in_q;
  logic               proc_fire;
  tes_pkg::out_item_t verdict;

  // The held item moves on unless it needs the result register and that
  // register is still waiting to be taken.
  assign proc_fire = in_q_valid &&
                     (!in_q.end_of_buffer || !out_valid || !out_stall);
  assign in_stall  = in_q_valid && !proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_q <= in_item;
    end
  end

  tes_scan #(
    .MIN_WIDE_WORDS(MIN_WIDE_WORDS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .take   (proc_fire),
    .item   (in_q),
    .verdict(verdict)
  );

  // Result register: a new verdict can replace one taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && in_q.end_of_buffer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && in_q.end_of_buffer) begin
      out_item <= verdict;
    end
  end

  // An empty buffer never reports an encoding or a mark.
  a_empty_is_default: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.detect_ok |->
      out_item.encoding_code == tes_pkg::ENC_DEFAULT && !out_item.bom_used)
    else $error("empty buffer verdict is not the default");

  // The mark flag and the mark length agree.
  a_bom_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.bom_used == (out_item.bom_bytes != tes_pkg::BOM_LEN_NONE)))
    else $error("bom_used and bom_bytes disagree");

  // The input stalls only behind a verdict that is itself stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && in_q.end_of_buffer && out_valid && out_stall)
    else $error("input stalled without a waiting verdict");

  // A processed end item always yields a verdict in the next cycle.
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    proc_fire && in_q.end_of_buffer |=> out_valid)
    else $error("verdict lost");

  // Codes above UTF-32LE are never produced.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.encoding_code <= tes_pkg::ENC_UTF32LE)
    else $error("encoding code out of range");

endmodule

/* tb/tes_verdict_checker.sv */
// Checker that predicts and compares the sniffer's buffer verdicts.
`timescale 1ns / 1ps

module tes_verdict_checker
  import tes_pkg::*;
#(
  parameter int MIN_WIDE_WORDS = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        pending,
  output int        fail_count
);

  // Bits of the per-order UTF-16 flag sets.
  localparam int FLG_UNIT = 0;
  localparam int FLG_OPEN = 1;
  localparam int FLG_FAIL = 2;

  // Bits of the UTF-32 failure flags.
  localparam int WIDE_BE = 0;
  localparam int WIDE_LE = 1;

  logic [31:0] head;
  logic [2:0]  nbytes;
  logic [1:0]  phase;
  logic [23:0] hold;
  logic [1:0]  u8_state;
  logic [2:0]  tails;
  logic [2:0]  be16;
  logic [2:0]  le16;
  logic [1:0]  wide_fail;
  logic [2:0]  nwords;

  out_item_t verdict_q[$];

  task automatic clear_scan();
    head      = '0;
    nbytes    = '0;
    phase     = '0;
    hold      = '0;
    u8_state  = U8_UNDECIDED;
    tails     = '0;
    be16      = '0;
    le16      = '0;
    wide_fail = '0;
    nwords    = '0;
  endtask

  // One UTF-16 code unit, given as high and low byte, against one byte order.
  function automatic logic [2:0] pair_step(logic [2:0] f, logic [7:0] hi, logic [7:0] lo);
    if (f[FLG_FAIL]) return f;
    if (hi == 8'h00) begin
      if (lo == 8'h00) f[FLG_FAIL] = 1'b1;
      else f[FLG_UNIT] = 1'b1;
    end else if (hi >= 8'hD8 && hi <= 8'hDB) begin
      if (f[FLG_OPEN]) f[FLG_FAIL] = 1'b1;
      else f[FLG_OPEN] = 1'b1;
    end else if (hi >= 8'hDC && hi <= 8'hDF) begin
      if (!f[FLG_OPEN]) f[FLG_FAIL] = 1'b1;
      else f[FLG_OPEN] = 1'b0;
    end
    return f;
  endfunction

  task automatic scan_byte(input logic [7:0] b);
    logic [31:0] be_word;
    logic [31:0] le_word;
    if (nbytes < 3'd4) head[8 * int'(nbytes) +: 8] = b;
    if (nbytes != 3'd7) nbytes++;

    if (u8_state == U8_UNDECIDED) begin
      if (tails != 3'd0) begin
        if (b[7:6] == 2'b10) begin
          tails--;
          if (tails == 3'd0) u8_state = U8_YES;
        end else begin
          u8_state = U8_NO;
        end
      end else if (b >= 8'h80) begin
        if (b <= 8'hDF) tails = 3'd1;
        else if (b <= 8'hEF) tails = 3'd2;
        else if (b <= 8'hF4) tails = 3'd3;
        else if (b <= 8'hFB) tails = 3'd4;
        else u8_state = U8_NO;
      end
    end

    if (phase[0]) begin
      be16 = pair_step(be16, hold[7:0], b);
      le16 = pair_step(le16, b, hold[7:0]);
    end

    if (phase == 2'd3) begin
      be_word = {hold, b};
      le_word = {b, hold[7:0], hold[15:8], hold[23:16]};
      if (be_word == 32'd0 || be_word > MAX_CODE_POINT) wide_fail[WIDE_BE] = 1'b1;
      if (le_word == 32'd0 || le_word > MAX_CODE_POINT) wide_fail[WIDE_LE] = 1'b1;
      if (nwords != 3'd7) nwords++;
    end

    hold = {hold[15:0], b};
    phase++;
  endtask

  function automatic out_item_t buffer_verdict();
    out_item_t v;
    logic      wide_ok;
    v = '0;
    wide_ok = (int'(nwords) >= MIN_WIDE_WORDS);
    if (nbytes != 3'd0) begin
      v.detect_ok = 1'b1;
      if (nbytes >= 3'd4) begin
        v.bom_used = 1'b1;
        if (head[7:0] == 8'hEF && head[15:8] == 8'hBB && head[23:16] == 8'hBF) begin
          v.encoding_code = ENC_UTF8;
          v.bom_bytes     = BOM_LEN_8;
        end else if (head == 32'hFFFE_0000) begin
          v.encoding_code = ENC_UTF32BE;
          v.bom_bytes     = BOM_LEN_32;
        end else if (head == 32'h0000_FEFF) begin
          v.encoding_code = ENC_UTF32LE;
          v.bom_bytes     = BOM_LEN_32;
        end else if (head[15:0] == 16'hFFFE) begin
          v.encoding_code = ENC_UTF16BE;
          v.bom_bytes     = BOM_LEN_16;
        end else if (head[15:0] == 16'hFEFF) begin
          v.encoding_code = ENC_UTF16LE;
          v.bom_bytes     = BOM_LEN_16;
        end else begin
          v.bom_used = 1'b0;
        end
      end
      if (!v.bom_used) begin
        if (u8_state == U8_YES) v.encoding_code = ENC_UTF8;
        else if (!be16[FLG_FAIL] && be16[FLG_UNIT]) v.encoding_code = ENC_UTF16BE;
        else if (!le16[FLG_FAIL] && le16[FLG_UNIT]) v.encoding_code = ENC_UTF16LE;
        else if (wide_ok && !wide_fail[WIDE_BE]) v.encoding_code = ENC_UTF32BE;
        else if (wide_ok && !wide_fail[WIDE_LE]) v.encoding_code = ENC_UTF32LE;
        else v.encoding_code = ENC_DEFAULT;
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      clear_scan();
      verdict_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_item.byte_present) scan_byte(in_item.data_byte);
        if (in_item.end_of_buffer) begin
          verdict_q.push_back(buffer_verdict());
          clear_scan();
        end
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected verdict: code %0d bom %0b len %0d ok %0b", $time,
                   out_item.encoding_code, out_item.bom_used, out_item.bom_bytes,
                   out_item.detect_ok);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (out_item.encoding_code !== want.encoding_code ||
              out_item.bom_used !== want.bom_used ||
              out_item.bom_bytes !== want.bom_bytes ||
              out_item.detect_ok !== want.detect_ok) begin
            $display("%0t: verdict mismatch: expected code %0d bom %0b len %0d ok %0b,",
                     $time, want.encoding_code, want.bom_used, want.bom_bytes,
                     want.detect_ok);
            $display("%0t:   got code %0d bom %0b len %0d ok %0b", $time,
                     out_item.encoding_code, out_item.bom_used, out_item.bom_bytes,
                     out_item.detect_ok);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= verdict_q.size();
  end

endmodule

/* tb/tb_text_encoding_sniffer_unit.sv */
// Testbench top for the text encoding sniffer: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module tb_text_encoding_sniffer_unit;
  import tes_pkg::*;

  localparam int MIN_WIDE_WORDS = 4;
  // Roughly how many items (bytes and end marks) the random part sends.
  localparam int ITEM_TARGET = 1350;
  // A verdict leaves from the result register after its item; the drain gives it some room.
  localparam int DRAIN_CYCLES = 8;
  // Far beyond the slowest legal run, even with heavy idling on both sides.
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int          pending;
  int          fail_count;
  int          items_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned cycle_count = 0;

  // Bytes of the buffer being put together before it is sent.
  logic [7:0] text_q[$];

  // Sender idle and receiver stall chances, in percent, for each phase of the run:
  // no idling, a slow sender, a slow receiver, and both moderately slow.
  int idle_tab[4]  = '{0, 77, 0, 32};
  int stall_tab[4] = '{0, 0, 77, 32};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_encoding_sniffer_unit #(
    .MIN_WIDE_WORDS(MIN_WIDE_WORDS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  tes_verdict_checker #(
    .MIN_WIDE_WORDS(MIN_WIDE_WORDS)
  ) u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .pending   (pending),
    .fail_count(fail_count)
  );

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one item and returns at the clock edge that accepts it. Valid is
  // left high on return, so the next item can follow without a gap; the
  // following call either lowers it for an idle cycle or drives the new item.
  task automatic push_item(input logic [7:0] b, input logic present, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, byte_present: present, end_of_buffer: last};
    do @(posedge clk); while (in_stall);
    // An absent byte with no end mark is ignored by the block, so it is not counted.
    if (present || last) items_sent++;
  endtask

  // Sends the queued bytes as one buffer. Absent-byte items are sprinkled in at
  // the given rate, and some buffers are closed by an absent-byte end item
  // rather than by their last byte. An empty queue gives an empty buffer.
  task automatic send_text(input int gap_pct);
    int  n;
    logic close_on_gap;
    n = text_q.size();
    close_on_gap = (n == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < gap_pct) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(text_q[i], 1'b1, !close_on_gap && i == n - 1);
    end
    if (close_on_gap) push_item(8'($urandom), 1'b0, 1'b1);
    text_q.delete();
  endtask

  task automatic put_unit(input bit little, input logic [15:0] u);
    if (little) begin
      text_q.push_back(u[7:0]);
      text_q.push_back(u[15:8]);
    end else begin
      text_q.push_back(u[15:8]);
      text_q.push_back(u[7:0]);
    end
  endtask

  task automatic put_word(input bit little, input logic [31:0] w);
    if (little) begin
      put_unit(1'b1, w[15:0]);
      put_unit(1'b1, w[31:16]);
    end else begin
      put_unit(1'b0, w[31:16]);
      put_unit(1'b0, w[15:0]);
    end
  endtask

  // Appends the byte order mark of the given encoding.
  task automatic add_bom(input logic [2:0] enc);
    case (enc)
      ENC_UTF8: begin
        text_q.push_back(8'hEF);
        text_q.push_back(8'hBB);
        text_q.push_back(8'hBF);
      end
      ENC_UTF32BE: put_word(1'b0, 32'h0000_FEFF);
      ENC_UTF32LE: put_word(1'b1, 32'h0000_FEFF);
      ENC_UTF16BE: put_unit(1'b0, 16'hFEFF);
      default:     put_unit(1'b1, 16'hFEFF);
    endcase
  endtask

  // UTF-8 style text. Lead bytes cover the whole range the heuristic knows,
  // including the 0x80 to 0xC1 and 0xF5 to 0xFB leads. A flawed buffer gets a
  // lead of 0xFC or above, a corrupted byte, or a sequence cut off at the end.
  task automatic add_utf8(input int chars, input bit flawed);
    int         ntail;
    logic [7:0] lead;
    for (int c = 0; c < chars; c++) begin
      case ($urandom_range(4))
        0, 1: begin
          lead  = 8'($urandom_range(8'h7F));
          ntail = 0;
        end
        2: begin
          lead  = 8'($urandom_range(8'h80, 8'hDF));
          ntail = 1;
        end
        3: begin
          lead  = 8'($urandom_range(8'hE0, 8'hEF));
          ntail = 2;
        end
        default: begin
          if ($urandom_range(3) == 0) begin
            lead  = 8'($urandom_range(8'hF5, 8'hFB));
            ntail = 4;
          end else begin
            lead  = 8'($urandom_range(8'hF0, 8'hF4));
            ntail = 3;
          end
        end
      endcase
      text_q.push_back(lead);
      for (int t = 0; t < ntail; t++) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end
    if (flawed && text_q.size() > 0) begin
      case ($urandom_range(2))
        0:       text_q.push_back(8'($urandom_range(8'hFC, 8'hFF)));
        1:       text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom);
        default: void'(text_q.pop_back());
      endcase
    end
  endtask

  // UTF-16 text in one byte order: zero-high units, other BMP units and
  // surrogate pairs. Flaws are a zero unit, a lone low surrogate, two high
  // surrogates in a row, or an odd trailing byte.
  task automatic add_utf16(input bit little, input int units, input bit flawed);
    logic [15:0] u;
    for (int k = 0; k < units; k++) begin
      case ($urandom_range(5))
        0, 1: u = {8'h00, 8'($urandom_range(1, 255))};
        2:    u = 16'($urandom_range(16'h0100, 16'hD7FF));
        3:    u = 16'($urandom_range(16'hE000, 16'hFFFF));
        default: begin
          put_unit(little, 16'($urandom_range(16'hD800, 16'hDBFF)));
          u = 16'($urandom_range(16'hDC00, 16'hDFFF));
        end
      endcase
      put_unit(little, u);
    end
    if (flawed) begin
      case ($urandom_range(3))
        0: put_unit(little, 16'h0000);
        1: put_unit(little, 16'($urandom_range(16'hDC00, 16'hDFFF)));
        2: begin
          put_unit(little, 16'($urandom_range(16'hD800, 16'hDBFF)));
          put_unit(little, 16'($urandom_range(16'hD800, 16'hDBFF)));
        end
        default: text_q.push_back(8'($urandom));
      endcase
    end
  endtask

  // UTF-32 words in one byte order, sometimes fewer than the check needs.
  // Flaws are a zero word or one above the largest code point; a partial
  // word may trail the buffer.
  task automatic add_utf32(input bit little, input int words, input bit flawed);
    logic [31:0] w;
    for (int k = 0; k < words; k++) begin
      case ($urandom_range(3))
        0:       w = 32'($urandom_range(1, 255));
        1:       w = 32'($urandom_range(1, 32'h0010_FFFF));
        2:       w = 32'($urandom_range(1, 32'h0000_FFFF));
        default: w = ($urandom_range(1) == 1) ? MAX_CODE_POINT : 32'd1;
      endcase
      put_word(little, w);
    end
    if (flawed) begin
      case ($urandom_range(2))
        0:       w = 32'd0;
        1:       w = 32'($urandom_range(32'h0011_0000, 32'hFFFF_FFFF));
        default: w = MAX_CODE_POINT + 32'd1;
      endcase
      put_word(little, w);
    end
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom));
    end
  endtask

  // Most buffers are text of one encoding with random content, a quarter of
  // them flawed; some carry a mark. The rest is raw noise and very short or
  // empty buffers.
  task automatic build_random_text();
    bit flawed;
    flawed = ($urandom_range(99) < 25);
    if ($urandom_range(3) == 0) add_bom(3'($urandom_range(ENC_UTF8, ENC_UTF32LE)));
    case ($urandom_range(9))
      0, 1: add_utf8($urandom_range(1, 6), flawed);
      2:    add_utf16(1'b0, $urandom_range(1, 6), flawed);
      3:    add_utf16(1'b1, $urandom_range(1, 6), flawed);
      4:    add_utf32(1'b0, $urandom_range(1, 7), flawed);
      5:    add_utf32(1'b1, $urandom_range(1, 7), flawed);
      6:    repeat ($urandom_range(12)) text_q.push_back(8'($urandom));
      7:    add_utf8($urandom_range(10, 25), flawed);
      default: repeat ($urandom_range(3)) text_q.push_back(8'($urandom));
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed buffers, sent with no idling on either side.
    // An empty buffer: a lone end item with no byte.
    push_item(8'hFF, 1'b0, 1'b1);
    // An absent byte without an end mark has no effect.
    push_item(8'h00, 1'b0, 1'b0);
    // A two-byte UTF-8 sequence with an absent byte between lead and tail.
    push_item(8'hC3, 1'b1, 1'b0);
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'hA9, 1'b1, 1'b1);
    // A byte of 0xFC can never lead a UTF-8 sequence.
    push_item(8'hFC, 1'b1, 1'b1);
    // A three-byte lead cut off by the end of the buffer.
    push_item(8'hE2, 1'b1, 1'b0);
    push_item(8'h82, 1'b1, 1'b1);
    // Marks in both wide byte orders, then a UTF-16BE mark ahead of one unit.
    add_bom(ENC_UTF32BE);
    send_text(0);
    add_bom(ENC_UTF32LE);
    send_text(0);
    add_bom(ENC_UTF16BE);
    put_unit(1'b0, 16'h0041);
    send_text(0);
    // The UTF-8 mark alone is too short for the mark check.
    add_bom(ENC_UTF8);
    send_text(0);

    // Random buffers, one phase of idling after another.
    items_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct <= stall_tab[ph];
      while (items_sent < (ph + 1) * ITEM_TARGET / 4) begin
        build_random_text();
        send_text(10);
      end
    end
    in_valid <= 1'b0;

    // Let every expected verdict arrive, then allow a few more cycles for
    // anything the block might still emit.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
